// ----- rtl/bfra_pkg.sv -----
// Shared types, codes and defaults of the best-fit region allocator.
package bfra_pkg;

	localparam int DEF_ALIGNMENT       = 256;
	localparam int DEF_MAX_ALLOCATIONS = 64;
	localparam logic [31:0] CAPACITY_RESET = 32'd16777216;
	localparam logic [47:0] BASE_RESET     = 48'd0;

	localparam logic CMD_ALLOC   = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	localparam logic REG_CAPACITY = 1'b0;
	localparam logic REG_BASE     = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK          = 2'd0,
		STAT_NO_FIT      = 2'd1,
		STAT_BAD_RELEASE = 2'd2,
		STAT_TABLE_FULL  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_FSCAN,
		S_USCAN,
		S_RSCAN,
		S_COMMIT,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic        command;
		logic [31:0] request_bytes;
		logic [47:0] release_address;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [47:0] granted_address;
		logic [31:0] live_bytes;
		logic [31:0] peak_bytes;
	} out_item_t;

	// Classified request as handed from the front to the back.
	typedef struct packed {
		logic        command;
		logic        rel_ok;
		logic [32:0] units;
		logic [31:0] target;
	} class_t;

endpackage

// ----- rtl/best_fit_region_allocator.sv -----
// Top level of the best-fit region allocator.
// Use: a request is written into the input queue with push while full is low;
// command selects allocate (rounded up to ALIGNMENT-byte units, at least one)
// or release of a previously granted address. Every request yields exactly one
// result, in order, read from the output queue with pop while empty is low:
// status, granted address, live and peak byte counts after the request.
// Operation: an allocate scans all MAX_ALLOCATIONS+1 free entries through one
// comparator and registered memory read. A release scans the allocation table
// until the start matches, then all free entries. One request is worked on at
// a time; the input queue keeps taking requests.
// Configuration: cfg_index selects capacity or base; writes are taken at
// once. A capacity write empties both tables and the byte counts, and the
// S_INIT state then rebuilds the single free segment. Reset does the same with a
// 16 MiB capacity and base zero.
// A stalled receiver fills the two-entry output queue; the back end then
// holds its finished result and stops, and the input queue fills behind it.
module best_fit_region_allocator import bfra_pkg::*; #(
	parameter int ALIGNMENT       = DEF_ALIGNMENT,
	parameter int MAX_ALLOCATIONS = DEF_MAX_ALLOCATIONS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  in_item_t    item,
	output logic        empty,
	input  logic        pop,
	output out_item_t   result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [47:0] cfg_data
);
	localparam int LA = $clog2(ALIGNMENT);
	localparam int UW = 32 - LA;

	logic [31:0] cap_q;
	logic [47:0] base_q;
	logic        reinit;
	class_t      cls, q_item;
	logic        q_empty, q_pop, q_full;
	logic        res_full, res_push;
	out_item_t   res_item;

	assign cfg_ready = 1'b1;
	assign reinit    = cfg_valid && (cfg_index == REG_CAPACITY);
	assign full      = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAPACITY_RESET;
			base_q <= BASE_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_CAPACITY) begin
				cap_q <= cfg_data[31:0];
			end else begin
				base_q <= cfg_data;
			end
		end
	end

	bfra_front #(.ALIGNMENT(ALIGNMENT)) u_front (
		.item (item),
		.base (base_q),
		.cls  (cls)
	);

	bfra_fifo #(.W($bits(class_t)), .DEPTH(2)) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cls),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_item),
		.empty  (q_empty)
	);

	bfra_back #(.ALIGNMENT(ALIGNMENT), .MAX_ALLOCATIONS(MAX_ALLOCATIONS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.reinit    (reinit),
		.cap_units (cap_q[31:32-UW]),
		.base      (base_q),
		.q_empty   (q_empty),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_item  (res_item)
	);

	bfra_fifo #(.W($bits(out_item_t)), .DEPTH(2)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_item),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

`ifndef ASSERT_OFF
	a_push_space: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full) else $error("result pushed into full queue");
	a_pop_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty) else $error("command taken from empty queue");
	a_peak_live: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.peak_bytes >= result.live_bytes)
		else $error("peak below live count");
`endif
endmodule

// ----- rtl/bfra_ram.sv -----
// Generic single write port RAM with registered read.
module bfra_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/bfra_fifo.sv -----
// Small register queue used between the parts of the allocator.
module bfra_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  buf_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = buf_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wptr_q] <= wdata;
		end
	end
endmodule

// ----- rtl/bfra_front.sv -----
// Front part: rounds requests to units and resolves release offsets.
module bfra_front import bfra_pkg::*; #(
	parameter int ALIGNMENT = DEF_ALIGNMENT
) (
	input  in_item_t    item,
	input  logic [47:0] base,
	output class_t      cls
);
	localparam int LA = $clog2(ALIGNMENT);

	logic [32:0] sum;
	logic [32:0] units;
	logic [47:0] offset;

	always_comb begin
		sum    = {1'b0, item.request_bytes} + 33'(ALIGNMENT - 1);
		units  = sum >> LA;
		offset = item.release_address - base;
		cls.command = item.command;
		cls.units   = (units == '0) ? 33'd1 : units;
		// Offset must be aligned and land inside the unit range.
		cls.rel_ok  = (offset[LA-1:0] == '0) && (offset[47:32] == '0);
		cls.target  = 32'(offset[31:LA]);
	end
endmodule

// ----- rtl/bfra_back.sv -----
// Back part: scans the segment tables and commits allocations and releases.
module bfra_back import bfra_pkg::*; #(
	parameter int ALIGNMENT       = DEF_ALIGNMENT,
	parameter int MAX_ALLOCATIONS = DEF_MAX_ALLOCATIONS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                reinit,
	input  logic [32-$clog2(ALIGNMENT)-1:0]     cap_units,
	input  logic [47:0]                         base,
	input  logic                                q_empty,
	input  class_t                              q_item,
	output logic                                q_pop,
	input  logic                                res_full,
	output logic                                res_push,
	output out_item_t                           res_item
);
	localparam int LA  = $clog2(ALIGNMENT);
	localparam int UW  = 32 - LA;
	localparam int FD  = MAX_ALLOCATIONS + 1;
	localparam int FAW = $clog2(FD);
	localparam int UAW = $clog2(MAX_ALLOCATIONS);
	localparam int CW  = $clog2(FD + 1);

	state_t state_q, state_d;

	logic [CW-1:0]  idx_q;
	logic           pend_q, pvld_q;
	logic [FAW-1:0] pidx_q;
	logic           cmd_q;
	logic [UW:0]    units_q;
	logic [UW-1:0]  tgt_q;
	logic           found_q, slot_found_q, prev_found_q, next_found_q, ins_found_q;
	logic [FAW-1:0] best_q, prev_q, next_q, ins_q;
	logic [UW-1:0]  bstart_q, blen_q, hlen_q, nlen_q;
	logic [UAW-1:0] slot_q, hit_q;
	status_t        stat_q;
	logic [47:0]    gaddr_q;
	logic [31:0]    live_q, peak_q;
	logic [FD-1:0]  fvalid_q;
	logic [MAX_ALLOCATIONS-1:0] uvalid_q;

	logic [2*UW-1:0] f_rdata, f_wdata, u_rdata, u_wdata;
	logic [FAW-1:0]  f_waddr;
	logic [UAW-1:0]  u_waddr;
	logic            f_we, u_we;

	logic           scanning, issue, issue_vld, done, hit;
	logic [CW-1:0]  scan_end;
	logic [UW-1:0]  fstart, flen, mlen;
	logic [UW:0]    fend;
	logic [FAW-1:0] ins_eff;
	logic           alloc_ok;
	logic [31:0]    live_new;

	bfra_ram #(.W(2*UW), .DEPTH(FD)) u_free_ram (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.raddr (idx_q[FAW-1:0]),
		.rdata (f_rdata)
	);

	bfra_ram #(.W(2*UW), .DEPTH(MAX_ALLOCATIONS)) u_used_ram (
		.clk   (clk),
		.we    (u_we),
		.waddr (u_waddr),
		.wdata (u_wdata),
		.raddr (idx_q[UAW-1:0]),
		.rdata (u_rdata)
	);

	assign fstart = f_rdata[2*UW-1:UW];
	assign flen   = f_rdata[UW-1:0];
	assign fend   = {1'b0, fstart} + {1'b0, flen};

	always_comb begin
		scanning = (state_q == S_FSCAN) || (state_q == S_USCAN) || (state_q == S_RSCAN);
		scan_end = (state_q == S_USCAN) ? CW'(MAX_ALLOCATIONS) : CW'(FD);
		issue    = scanning && (idx_q != scan_end);
		done     = scanning && (idx_q == scan_end) && !pend_q;
		hit      = (state_q == S_USCAN) && pend_q && pvld_q
			&& (u_rdata[2*UW-1:UW] == tgt_q);
		issue_vld = 1'b0;
		if (issue) begin
			if (state_q == S_USCAN) begin
				issue_vld = uvalid_q[idx_q[UAW-1:0]];
			end else begin
				issue_vld = fvalid_q[idx_q[FAW-1:0]];
			end
		end
		alloc_ok = found_q && slot_found_q;
		mlen     = hlen_q + (next_found_q ? nlen_q : '0);
		ins_eff  = (next_found_q && (!ins_found_q || next_q < ins_q)) ? next_q : ins_q;
		if (cmd_q == CMD_ALLOC) begin
			live_new = live_q + (32'(units_q[UW-1:0]) << LA);
		end else begin
			live_new = live_q - (32'(hlen_q) << LA);
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT:  state_d = S_IDLE;
			S_IDLE: begin
				if (!q_empty) begin
					if (q_item.command == CMD_ALLOC) begin
						state_d = S_FSCAN;
					end else if (q_item.rel_ok) begin
						state_d = S_USCAN;
					end else begin
						state_d = S_EMIT;
					end
				end
			end
			S_FSCAN: if (done) state_d = S_COMMIT;
			S_USCAN: begin
				if (hit) begin
					state_d = S_RSCAN;
				end else if (done) begin
					state_d = S_EMIT;
				end
			end
			S_RSCAN:  if (done) state_d = S_COMMIT;
			S_COMMIT: state_d = S_EMIT;
			S_EMIT:   if (!res_full) state_d = S_IDLE;
			default:  state_d = S_INIT;
		endcase
	end

	// Outputs and table writes.
	always_comb begin
		q_pop    = (state_q == S_IDLE) && !q_empty;
		res_push = (state_q == S_EMIT) && !res_full;
		res_item.status          = stat_q;
		res_item.granted_address = gaddr_q;
		res_item.live_bytes      = live_q;
		res_item.peak_bytes      = peak_q;
		f_we    = 1'b0;
		f_waddr = '0;
		f_wdata = '0;
		u_we    = 1'b0;
		u_waddr = slot_q;
		u_wdata = {bstart_q, units_q[UW-1:0]};
		unique case (state_q)
			S_INIT: begin
				f_we    = 1'b1;
				f_wdata = {{UW{1'b0}}, cap_units};
			end
			S_COMMIT: begin
				if (cmd_q == CMD_ALLOC) begin
					u_we    = alloc_ok;
					f_we    = alloc_ok && (blen_q != units_q[UW-1:0]);
					f_waddr = best_q;
					f_wdata = {bstart_q + units_q[UW-1:0], blen_q - units_q[UW-1:0]};
				end else begin
					f_we = 1'b1;
					if (prev_found_q) begin
						f_waddr = prev_q;
						f_wdata = {bstart_q, blen_q + mlen};
					end else begin
						f_waddr = ins_eff;
						f_wdata = {tgt_q, mlen};
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_INIT;
			fvalid_q <= '0;
			uvalid_q <= '0;
			live_q   <= '0;
			peak_q   <= '0;
			idx_q    <= '0;
			pend_q   <= 1'b0;
		end else if (reinit) begin
			state_q  <= S_INIT;
			fvalid_q <= '0;
			uvalid_q <= '0;
			live_q   <= '0;
			peak_q   <= '0;
			pend_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			// Scan pipeline: issue a read, check its data next cycle.
			if (issue) begin
				idx_q  <= idx_q + CW'(1);
				pend_q <= 1'b1;
			end else begin
				pend_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: fvalid_q[0] <= (cap_units != '0);
				S_IDLE: begin
					idx_q  <= '0;
					pend_q <= 1'b0;
				end
				S_USCAN: begin
					if (hit) begin
						idx_q  <= '0;
						pend_q <= 1'b0;
					end
				end
				S_COMMIT: begin
					if (cmd_q == CMD_ALLOC) begin
						if (alloc_ok) begin
							uvalid_q[slot_q] <= 1'b1;
							if (blen_q == units_q[UW-1:0]) begin
								fvalid_q[best_q] <= 1'b0;
							end
							live_q <= live_new;
							if (live_new > peak_q) begin
								peak_q <= live_new;
							end
						end
					end else begin
						uvalid_q[hit_q] <= 1'b0;
						live_q <= live_new;
						if (next_found_q) begin
							fvalid_q[next_q] <= 1'b0;
						end
						if (!prev_found_q) begin
							fvalid_q[ins_eff] <= 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Per-item payload registers.
	always_ff @(posedge clk) begin
		if (issue) begin
			pidx_q <= idx_q[FAW-1:0];
			pvld_q <= issue_vld;
		end
		unique case (state_q)
			S_IDLE: begin
				cmd_q        <= q_item.command;
				units_q      <= q_item.units[UW:0];
				tgt_q        <= q_item.target[UW-1:0];
				found_q      <= 1'b0;
				slot_found_q <= 1'b0;
				prev_found_q <= 1'b0;
				next_found_q <= 1'b0;
				ins_found_q  <= 1'b0;
				stat_q       <= STAT_BAD_RELEASE;
				gaddr_q      <= '0;
			end
			S_FSCAN: begin
				if (issue && !slot_found_q && idx_q < CW'(MAX_ALLOCATIONS)) begin
					if (!uvalid_q[idx_q[UAW-1:0]]) begin
						slot_found_q <= 1'b1;
						slot_q       <= idx_q[UAW-1:0];
					end
				end
				if (pend_q && pvld_q && ({1'b0, flen} >= units_q)) begin
					if (!found_q || flen < blen_q || (flen == blen_q && fstart < bstart_q)) begin
						found_q  <= 1'b1;
						best_q   <= pidx_q;
						bstart_q <= fstart;
						blen_q   <= flen;
					end
				end
			end
			S_USCAN: begin
				if (hit) begin
					hit_q  <= pidx_q[UAW-1:0];
					hlen_q <= u_rdata[UW-1:0];
				end
			end
			S_RSCAN: begin
				if (issue && !ins_found_q && !issue_vld) begin
					ins_found_q <= 1'b1;
					ins_q       <= idx_q[FAW-1:0];
				end
				if (pend_q && pvld_q) begin
					if (fend == {1'b0, tgt_q}) begin
						prev_found_q <= 1'b1;
						prev_q       <= pidx_q;
						bstart_q     <= fstart;
						blen_q       <= flen;
					end else if ({1'b0, fstart} == {1'b0, tgt_q} + {1'b0, hlen_q}) begin
						next_found_q <= 1'b1;
						next_q       <= pidx_q;
						nlen_q       <= flen;
					end
				end
			end
			S_COMMIT: begin
				if (cmd_q == CMD_ALLOC) begin
					if (!found_q) begin
						stat_q <= STAT_NO_FIT;
					end else if (!slot_found_q) begin
						stat_q <= STAT_TABLE_FULL;
					end else begin
						stat_q  <= STAT_OK;
						gaddr_q <= base + (48'(bstart_q) << LA);
					end
				end else begin
					stat_q <= STAT_OK;
				end
			end
			default: ;
		endcase
	end
endmodule

// ----- verif/bfra_checker.sv -----
// Scoreboard for the best-fit region allocator: predicts each result and compares it.
`timescale 1ns / 1ps
module bfra_checker import bfra_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  in_item_t    item,
	input  logic        empty,
	input  logic        pop,
	input  out_item_t   result,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [47:0] cfg_data,
	output int          errors,
	output logic        drained
);

	localparam int UNIT  = DEF_ALIGNMENT;
	localparam int SLOTS = DEF_MAX_ALLOCATIONS;
	localparam int SEGS  = DEF_MAX_ALLOCATIONS + 1;

	logic [31:0] capacity;
	logic [47:0] base;
	logic [31:0] seg_start [SEGS];
	logic [31:0] seg_len   [SEGS];
	logic        seg_live  [SEGS];
	logic [31:0] span_start [SLOTS];
	logic [31:0] span_len   [SLOTS];
	logic        span_live  [SLOTS];
	logic [31:0] live_total;
	logic [31:0] peak_total;
	out_item_t   expected_q [$];

	assign drained = (expected_q.size() == 0);

	function automatic void rebuild_region();
		for (int i = 0; i < SEGS; i++) begin
			seg_start[i] = '0;
			seg_len[i]   = '0;
			seg_live[i]  = 1'b0;
		end
		for (int i = 0; i < SLOTS; i++) begin
			span_start[i] = '0;
			span_len[i]   = '0;
			span_live[i]  = 1'b0;
		end
		if (capacity / UNIT != 0) begin
			seg_live[0] = 1'b1;
			seg_len[0]  = capacity / UNIT;
		end
		live_total = '0;
		peak_total = '0;
	endfunction

	function automatic out_item_t predict_allocate(logic [31:0] req);
		out_item_t   r;
		logic [32:0] units;
		int          best;
		int          slot;
		best  = -1;
		slot  = -1;
		units = ({1'b0, req} + UNIT - 1) / UNIT;
		if (units == 0)
			units = 1;
		for (int i = 0; i < SEGS; i++) begin
			if (!seg_live[i] || {1'b0, seg_len[i]} < units)
				continue;
			if (best < 0 || seg_len[i] < seg_len[best] ||
			    (seg_len[i] == seg_len[best] && seg_start[i] < seg_start[best]))
				best = i;
		end
		r.granted_address = '0;
		if (best < 0) begin
			r.status = STAT_NO_FIT;
		end else begin
			for (int i = 0; i < SLOTS; i++)
				if (!span_live[i] && slot < 0)
					slot = i;
			if (slot < 0) begin
				r.status = STAT_TABLE_FULL;
			end else begin
				span_live[slot]  = 1'b1;
				span_start[slot] = seg_start[best];
				span_len[slot]   = units[31:0];
				if ({1'b0, seg_len[best]} == units) begin
					seg_live[best] = 1'b0;
				end else begin
					seg_start[best] += units[31:0];
					seg_len[best]   -= units[31:0];
				end
				live_total += units[31:0] * UNIT;
				if (live_total > peak_total)
					peak_total = live_total;
				r.status          = STAT_OK;
				r.granted_address = base + {16'd0, span_start[slot]} * UNIT;
			end
		end
		r.live_bytes = live_total;
		r.peak_bytes = peak_total;
		return r;
	endfunction

	function automatic out_item_t predict_release(logic [47:0] addr);
		out_item_t   r;
		logic [47:0] offset;
		logic [32:0] start;
		logic [32:0] len;
		int          hit;
		int          prev;
		int          next;
		hit    = -1;
		prev   = -1;
		next   = -1;
		offset = addr - base;
		if (offset % UNIT == 0)
			for (int i = 0; i < SLOTS; i++)
				if (hit < 0 && span_live[i] && {16'd0, span_start[i]} == offset / UNIT)
					hit = i;
		r.granted_address = '0;
		if (hit < 0) begin
			r.status = STAT_BAD_RELEASE;
		end else begin
			start = span_start[hit];
			len   = span_len[hit];
			span_live[hit] = 1'b0;
			live_total -= len[31:0] * UNIT;
			for (int i = 0; i < SEGS; i++) begin
				if (!seg_live[i])
					continue;
				if ({1'b0, seg_start[i]} + seg_len[i] == start)
					prev = i;
				else if ({1'b0, seg_start[i]} == start + len)
					next = i;
			end
			// fold the following free segment in first, then extend or add
			if (next >= 0) begin
				len += seg_len[next];
				seg_live[next] = 1'b0;
			end
			if (prev >= 0) begin
				seg_len[prev] += len[31:0];
			end else begin
				for (int i = 0; i < SEGS; i++)
					if (!seg_live[i]) begin
						seg_live[i]  = 1'b1;
						seg_start[i] = start[31:0];
						seg_len[i]   = len[31:0];
						break;
					end
			end
			r.status = STAT_OK;
		end
		r.live_bytes = live_total;
		r.peak_bytes = peak_total;
		return r;
	endfunction

	// Outputs move only on rising edges, so sample every channel at the falling edge.
	always @(negedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			capacity = CAPACITY_RESET;
			base     = BASE_RESET;
			rebuild_region();
			expected_q.delete();
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_CAPACITY) begin
					capacity = cfg_data[31:0] - cfg_data[31:0] % UNIT;
					rebuild_region();
				end else begin
					base = cfg_data;
				end
			end
			if (push && !full) begin
				if (item.command == CMD_ALLOC)
					expected_q.push_back(predict_allocate(item.request_bytes));
				else
					expected_q.push_back(predict_release(item.release_address));
			end
			if (pop && !empty) begin
				if (expected_q.size() == 0) begin
					$error("result beat with no request outstanding");
					errors++;
				end else begin
					want = expected_q.pop_front();
					if (result.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, result.status);
						errors++;
					end
					if (result.granted_address !== want.granted_address) begin
						$error("granted_address: expected %h, actual %h",
							want.granted_address, result.granted_address);
						errors++;
					end
					if (result.live_bytes !== want.live_bytes) begin
						$error("live_bytes: expected %0d, actual %0d",
							want.live_bytes, result.live_bytes);
						errors++;
					end
					if (result.peak_bytes !== want.peak_bytes) begin
						$error("peak_bytes: expected %0d, actual %0d",
							want.peak_bytes, result.peak_bytes);
						errors++;
					end
				end
			end
		end
	end

endmodule

// ----- verif/tb_best_fit_region_allocator.sv -----
// Stimulus, clock, reset and verdict for the best-fit region allocator.
`timescale 1ns / 1ps
module tb_best_fit_region_allocator;
	import bfra_pkg::*;

	localparam int STALL_LIMIT = 5000;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        push      = 1'b0;
	logic        full;
	in_item_t    item      = '0;
	logic        empty;
	logic        pop       = 1'b0;
	out_item_t   result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = REG_CAPACITY;
	logic [47:0] cfg_data  = '0;
	int          errors;
	logic        drained;

	int          send_idle = 0;
	int          recv_idle = 0;
	int          quiet_cycles = 0;
	logic        command_q [$];
	logic [47:0] granted_q [$];
	logic [31:0] capacity_now;

	always #6 clk = ~clk;

	best_fit_region_allocator DUT (
		.clk, .arst_n, .push, .full, .item, .empty, .pop, .result,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	bfra_checker u_checker (
		.clk, .arst_n, .push, .full, .item, .empty, .pop, .result,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .errors, .drained
	);

	always @(posedge clk)
		if (arst_n)
			pop <= ($urandom_range(0, 99) >= recv_idle);

	// Track live grants so that most releases name a real span.
	always @(negedge clk) begin
		logic c;
		if (arst_n && pop && !empty) begin
			c = command_q.pop_front();
			if (c == CMD_ALLOC && result.status == STAT_OK)
				granted_q.push_back(result.granted_address);
		end
	end

	always @(negedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Push stays high after a beat so that the next item can follow at once.
	task automatic send(logic cmd, logic [31:0] bytes, logic [47:0] addr);
		logic taken;
		while ($urandom_range(0, 99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= '{command: cmd, request_bytes: bytes, release_address: addr};
		do begin
			@(negedge clk);
			taken = !full;
			@(posedge clk);
		end while (!taken);
		command_q.push_back(cmd);
	endtask

	task automatic settle();
		push <= 1'b0;
		while (!drained || command_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [47:0] value);
		logic taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		cfg_valid <= 1'b0;
		if (idx == REG_CAPACITY) begin
			capacity_now = value[31:0];
			granted_q.delete();
		end
		@(posedge clk);
	endtask

	task automatic release_any();
		int k;
		logic [47:0] a;
		if (granted_q.size() != 0 && $urandom_range(0, 9) < 8) begin
			k = $urandom_range(0, granted_q.size() - 1);
			a = granted_q[k];
			granted_q.delete(k);
			send(CMD_RELEASE, $urandom, a);
		end else if (granted_q.size() != 0 && $urandom_range(0, 1) == 0) begin
			send(CMD_RELEASE, $urandom,
				granted_q[$urandom_range(0, granted_q.size() - 1)] + $urandom_range(1, 255));
		end else begin
			send(CMD_RELEASE, $urandom, 48'({$urandom, $urandom}));
		end
	endtask

	initial begin
		logic [31:0] caps [5];
		logic [47:0] bases [5];
		logic [31:0] req;
		capacity_now = CAPACITY_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: rounding edges, oversize, release cases
		send(CMD_ALLOC, 32'd0, '0);
		send(CMD_ALLOC, 32'd1, '0);
		send(CMD_ALLOC, 32'd256, '0);
		send(CMD_ALLOC, 32'd257, '0);
		send(CMD_ALLOC, 32'hFFFF_FFFF, '0);
		settle();
		send(CMD_RELEASE, '0, granted_q[1]);
		send(CMD_RELEASE, '0, granted_q[0] + 48'd1);
		send(CMD_RELEASE, '0, 48'hFFFF_FFFF_FF00);
		send(CMD_RELEASE, '0, granted_q[0]);
		send(CMD_RELEASE, '0, granted_q[2]);
		send(CMD_ALLOC, 32'd512, '0);
		settle();
		// region smaller than one unit
		write_reg(REG_CAPACITY, 48'd0);
		send(CMD_ALLOC, 32'd5, '0);
		send(CMD_RELEASE, '0, '0);
		settle();
		write_reg(REG_CAPACITY, 48'd255);
		send(CMD_ALLOC, 32'd0, '0);
		settle();
		// largest region at the top of the address space, offsets wrap
		write_reg(REG_BASE, 48'hFFFF_FFFF_FFFF);
		write_reg(REG_CAPACITY, 48'hFFFF_FFFF);
		send(CMD_ALLOC, 32'hFFFF_FF00, '0);
		send(CMD_ALLOC, 32'd1, '0);
		settle();
		send(CMD_RELEASE, '0, granted_q[0]);
		send(CMD_ALLOC, 32'hFFFF_FE01, '0);
		settle();

		caps  = '{32'h0000_1000, 32'h0100_0000, 32'h0001_0000, $urandom, 32'h0100_0000};
		bases = '{48'd0, 48'({$urandom, $urandom}), 48'hFFFF_FFFF_FF00,
			48'({$urandom, $urandom}), 48'h8000_0000_0000};
		for (int p = 0; p < 5; p++) begin
			send_idle = (p < 2) ? 32 : (p < 4) ? 67 : 0;
			recv_idle = (p < 2) ? 67 : (p < 4) ? 32 : 0;
			write_reg(REG_BASE, bases[p]);
			write_reg(REG_CAPACITY, {16'd0, caps[p]});
			for (int n = 0; n < 170; n++) begin
				if ($urandom_range(0, 99) < 60) begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4, 5: req = $urandom_range(0, 4096);
						6, 7:             req = $urandom_range(0, 300);
						8:                req = $urandom;
						default:          req = $urandom_range(0, capacity_now);
					endcase
					send(CMD_ALLOC, req, 48'({$urandom, $urandom}));
				end else begin
					release_any();
				end
			end
			settle();
		end

		repeat (150) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
